// File: rtl/i2crm_pkg.sv
// Shared types and constants of the register-map bootloader slave.
// No dependencies; the core, front end and back end import this package.
`default_nettype none

package i2crm_pkg;

   localparam int         MAP_DEPTH_DEF = 256;
   localparam logic [7:0] BUSY_MASK_DEF = 8'h01;

   // Fixed map addresses
   localparam logic [7:0] ADDR_STATUS       = 8'd1;
   localparam logic [7:0] ADDR_RESTART      = 8'd2;
   localparam logic [7:0] ADDR_PROGRAM      = 8'd3;
   localparam logic [7:0] ADDR_DEBUG        = 8'd4;
   localparam logic [7:0] ADDR_LAST_CONTROL = 8'd4;
   localparam logic [7:0] ADDR_FLASH_ADDR   = 8'd124;

   // Bus event codes on the request channel
   localparam logic [2:0] OP_START = 3'd0;
   localparam logic [2:0] OP_STOP  = 3'd1;
   localparam logic [2:0] OP_WRITE = 3'd2;
   localparam logic [2:0] OP_READ  = 3'd3;
   localparam logic [2:0] OP_TICK  = 3'd4;

   // Configuration register indexes
   localparam logic CSR_RESTART_KEY = 1'b0;
   localparam logic CSR_PROGRAM_KEY = 1'b1;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_START_RD,
      CMD_START_WR,
      CMD_STOP,
      CMD_WRITE,
      CMD_READ,
      CMD_TICK
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   data;
      logic         nack;
   } cmd_type;

   typedef struct packed {
      logic [7:0] restart_key;
      logic [7:0] program_key;
   } keys_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic        read_valid;
      logic        write_nack;
      logic        flash_request;
      logic [31:0] flash_address;
      logic        led_level;
      logic        start_application;
   } rsp_type;

endpackage

`default_nettype wire

// File: rtl/i2c_register_map_bootloader_slave_core.sv
// Register-map bootloader slave: key registers plus front and back ends.
// Depends on i2crm_pkg, i2crm_front and i2crm_back.
//
// Usage:
//   Request channel (req_*): one beat per bus event (start, stop, written
//   byte, read byte, service tick). A beat is taken when req_push is high
//   and req_full is low. A two-beat command queue sits behind it.
//   Result channel (rsp_*): exactly one result beat per request beat, in
//   order. The beat on the ports is valid while rsp_empty is low and is
//   taken when rsp_pop is high.
//   Key registers (csr_*): write restart and program keys with csr_we while
//   the block is idle; no read-back.
// Path: a request passes the command queue and then the result register;
//   a read that returns data also waits for the registered map memory read.
// Throughput: one beat per cycle while rsp_pop keeps the result beat moving;
//   a data read holds the back end in its read state for the registered map read.
// Reset: synchronous. Afterwards the back end zeroes the map one entry per
//   cycle, all MAP_DEPTH (256) entries, with req_full held high meanwhile.
// Stall: if rsp_pop stays low the result beat holds, the back end stops,
//   and the command queue fills until req_full rises.
`default_nettype none

module i2c_register_map_bootloader_slave_core
   import i2crm_pkg::*;
#(
   parameter int         MAP_DEPTH = MAP_DEPTH_DEF,
   parameter logic [7:0] BUSY_MASK = BUSY_MASK_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request beats
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [2:0]  req_op,
   input  wire logic        req_is_read,
   input  wire logic [7:0]  req_data_in,
   input  wire logic        req_master_nack,
   // result beats
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [7:0]       rsp_read_data,
   output logic             rsp_read_valid,
   output logic             rsp_write_nack,
   output logic             rsp_flash_request,
   output logic [31:0]      rsp_flash_address,
   output logic             rsp_led_level,
   output logic             rsp_start_application,
   // key registers
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [7:0]  csr_wdata
);

   keys_type keys_ff, keys_in;
   logic     fe_full;
   logic     req_accept;
   logic     cmd_valid;
   cmd_type  cmd;
   logic     cmd_pop;
   logic     clearing;
   logic     rsp_valid;
   rsp_type  rsp;

   // key registers
   always_comb begin
      keys_in = keys_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_RESTART_KEY: keys_in.restart_key = csr_wdata;
            CSR_PROGRAM_KEY: keys_in.program_key = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         keys_ff <= '0;
      end else begin
         keys_ff <= keys_in;
      end
   end

   // hold off new beats while the map clearing pass runs
   assign req_full   = fe_full || clearing;
   assign req_accept = req_push && !req_full;

   i2crm_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .op          (req_op),
      .is_read     (req_is_read),
      .data_in     (req_data_in),
      .master_nack (req_master_nack),
      .full        (fe_full),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cmd_pop     (cmd_pop)
   );

   i2crm_back #(
      .MAP_DEPTH (MAP_DEPTH),
      .BUSY_MASK (BUSY_MASK)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .keys      (keys_ff),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .clearing  (clearing),
      .rsp_pop   (rsp_pop),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   // unpack the result beat
   assign rsp_empty             = !rsp_valid;
   assign rsp_read_data         = rsp.read_data;
   assign rsp_read_valid        = rsp.read_valid;
   assign rsp_write_nack        = rsp.write_nack;
   assign rsp_flash_request     = rsp.flash_request;
   assign rsp_flash_address     = rsp.flash_address;
   assign rsp_led_level         = rsp.led_level;
   assign rsp_start_application = rsp.start_application;

endmodule

`default_nettype wire

// File: rtl/i2crm_front.sv
// Front end: decodes each request beat into a command and queues it.
// Depends on i2crm_pkg.
`default_nettype none

module i2crm_front
   import i2crm_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic [2:0] op,
   input  wire logic       is_read,
   input  wire logic [7:0] data_in,
   input  wire logic       master_nack,
   output logic            full,
   output logic            cmd_valid,
   output cmd_type         cmd,
   input  wire logic       cmd_pop
);

   cmd_type    cmd_new;
   cmd_type    q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_pop;

   // classify the event
   always_comb begin
      cmd_new.data = data_in;
      cmd_new.nack = master_nack;
      case (op)
         OP_START: cmd_new.kind = is_read ? CMD_START_RD : CMD_START_WR;
         OP_STOP:  cmd_new.kind = CMD_STOP;
         OP_WRITE: cmd_new.kind = CMD_WRITE;
         OP_READ:  cmd_new.kind = CMD_READ;
         OP_TICK:  cmd_new.kind = CMD_TICK;
         default:  cmd_new.kind = CMD_NONE;
      endcase
   end

   always_comb begin
      do_pop    = cmd_pop && (count_ff != 2'd0);
      wr_ptr_in = wr_ptr_ff ^ accept;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, accept} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         q_ff[wr_ptr_ff] <= cmd_new;
      end
   end

   assign full      = (count_ff == 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];

endmodule

`default_nettype wire

// File: rtl/i2crm_back.sv
// Back end: executes queued commands against the register map and holds the result beat.
// Depends on i2crm_pkg; contains the map memory and its clearing pass.
`default_nettype none

module i2crm_back
   import i2crm_pkg::*;
#(
   parameter int         MAP_DEPTH = MAP_DEPTH_DEF,
   parameter logic [7:0] BUSY_MASK = BUSY_MASK_DEF
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire keys_type keys,
   input  wire logic     cmd_valid,
   input  wire cmd_type  cmd,
   output logic          cmd_pop,
   output logic          clearing,
   input  wire logic     rsp_pop,
   output logic          rsp_valid,
   output rsp_type       rsp
);

   localparam int             AW       = $clog2(MAP_DEPTH);
   localparam logic [AW-1:0]  LAST_IDX = AW'(MAP_DEPTH - 1);

   typedef enum logic [1:0] {ST_CLEAR, ST_RUN, ST_READ} state_type;
   typedef enum logic [1:0] {MODE_IDLE, MODE_READ, MODE_WRITE} mode_type;

   logic [7:0]    map_mem [MAP_DEPTH];
   logic [7:0]    mem_rdata_ff;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [7:0]    mem_wdata;

   state_type     state_ff, state_in;
   mode_type      mode_ff, mode_in;
   logic [AW-1:0] clr_idx_ff, clr_idx_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic          expect_ff, expect_in;
   logic          first_ff, first_in;
   logic          led_ff, led_in;
   logic          exited_ff, exited_in;
   logic [7:0]    status_ff, status_in;
   logic [7:0]    restart_ff, restart_in;
   logic [7:0]    program_ff, program_in;
   logic [7:0]    debug_ff, debug_in;
   logic [7:0]    fa_ff [4];
   logic [7:0]    fa_in [4];
   logic          rd_status_ff, rd_status_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;
   rsp_type       r;
   logic          rsp_load;
   logic          out_free;

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      clr_idx_in   = clr_idx_ff;
      ptr_in       = ptr_ff;
      expect_in    = expect_ff;
      first_in     = first_ff;
      led_in       = led_ff;
      exited_in    = exited_ff;
      status_in    = status_ff;
      restart_in   = restart_ff;
      program_in   = program_ff;
      debug_in     = debug_ff;
      fa_in        = fa_ff;
      rd_status_in = rd_status_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_waddr    = ptr_ff;
      mem_wdata    = cmd.data;
      cmd_pop      = 1'b0;
      rsp_load     = 1'b0;
      r            = '0;
      out_free     = !rsp_valid_ff || rsp_pop;

      case (state_ff)
         ST_CLEAR: begin
            // sweep zeros through the map, one entry a cycle
            mem_we    = 1'b1;
            mem_waddr = clr_idx_ff;
            mem_wdata = 8'd0;
            if (clr_idx_ff == LAST_IDX) begin
               state_in = ST_RUN;
            end else begin
               clr_idx_in = clr_idx_ff + AW'(1);
            end
         end
         ST_RUN: begin
            if (cmd_valid && out_free) begin
               cmd_pop  = 1'b1;
               rsp_load = 1'b1;
               if (exited_ff) begin
                  r.write_nack = (cmd.kind == CMD_WRITE);
               end else begin
                  case (cmd.kind)
                     CMD_START_RD: begin
                        mode_in  = MODE_READ;
                        first_in = 1'b1;
                     end
                     CMD_START_WR: begin
                        mode_in   = MODE_WRITE;
                        expect_in = 1'b1;
                     end
                     CMD_STOP: mode_in = MODE_IDLE;
                     CMD_WRITE: begin
                        if (mode_ff != MODE_WRITE) begin
                           r.write_nack = 1'b1;
                        end else if (expect_ff) begin
                           ptr_in    = cmd.data[AW-1:0];
                           expect_in = 1'b0;
                        end else begin
                           mem_we = 1'b1;
                           // mirror the bytes the service pass looks at
                           if (ptr_ff == AW'(ADDR_STATUS))  status_in  = cmd.data;
                           if (ptr_ff == AW'(ADDR_RESTART)) restart_in = cmd.data;
                           if (ptr_ff == AW'(ADDR_PROGRAM)) program_in = cmd.data;
                           if (ptr_ff == AW'(ADDR_DEBUG))   debug_in   = cmd.data;
                           if ({ptr_ff[AW-1:2], 2'b00} == AW'(ADDR_FLASH_ADDR)) begin
                              fa_in[ptr_ff[1:0]] = cmd.data;
                           end
                           if (ptr_ff <= AW'(ADDR_LAST_CONTROL)) begin
                              status_in = status_in | BUSY_MASK;
                           end else begin
                              ptr_in = ptr_ff + AW'(1);
                           end
                        end
                     end
                     CMD_READ: begin
                        if (mode_ff == MODE_READ) begin
                           ptr_in = ptr_ff + AW'(1);
                           if (!(cmd.nack && !first_ff)) begin
                              // wait in ST_READ for the registered map read
                              first_in     = 1'b0;
                              rd_status_in = (ptr_ff == AW'(ADDR_STATUS));
                              state_in     = ST_READ;
                              rsp_load     = 1'b0;
                           end
                        end
                     end
                     CMD_TICK: begin
                        if (status_ff != 8'd0) begin
                           status_in = 8'd0;
                           if (ptr_ff == AW'(ADDR_RESTART)) begin
                              if (restart_ff == keys.restart_key) begin
                                 exited_in = 1'b1;
                                 status_in = status_ff;
                              end
                           end else if (ptr_ff == AW'(ADDR_PROGRAM)) begin
                              if (program_ff == keys.program_key) begin
                                 r.flash_request = 1'b1;
                                 r.flash_address = {fa_ff[3], fa_ff[2], fa_ff[1], fa_ff[0]};
                              end
                           end else if (ptr_ff == AW'(ADDR_DEBUG)) begin
                              led_in = (debug_ff == 8'd0);
                           end
                        end
                     end
                     default: ;
                  endcase
               end
               r.led_level         = led_in;
               r.start_application = exited_in;
            end
         end
         ST_READ: begin
            rsp_load            = 1'b1;
            r.read_data         = rd_status_ff ? status_ff : mem_rdata_ff;
            r.read_valid        = 1'b1;
            r.led_level         = led_ff;
            r.start_application = exited_ff;
            state_in            = ST_RUN;
         end
         default: state_in = ST_CLEAR;
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_in       = r;
      end else if (rsp_pop) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         mode_ff      <= MODE_IDLE;
         clr_idx_ff   <= '0;
         ptr_ff       <= '0;
         expect_ff    <= 1'b1;
         first_ff     <= 1'b0;
         led_ff       <= 1'b1;
         exited_ff    <= 1'b0;
         status_ff    <= 8'd0;
         restart_ff   <= 8'd0;
         program_ff   <= 8'd0;
         debug_ff     <= 8'd0;
         fa_ff        <= '{default: 8'd0};
         rd_status_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         clr_idx_ff   <= clr_idx_in;
         ptr_ff       <= ptr_in;
         expect_ff    <= expect_in;
         first_ff     <= first_in;
         led_ff       <= led_in;
         exited_ff    <= exited_in;
         status_ff    <= status_in;
         restart_ff   <= restart_in;
         program_ff   <= program_in;
         debug_ff     <= debug_in;
         fa_ff        <= fa_in;
         rd_status_ff <= rd_status_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_ff       <= rsp_in;
      end
   end

   // map memory: one write port, one registered read at the pointer
   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= map_mem[ptr_ff];
   end

   assign clearing  = (state_ff == ST_CLEAR);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

`default_nettype wire

// File: rtl/i2crm_checker.sv
// Port-level checks for the register-map bootloader slave, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module i2crm_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_full,
   input wire logic        rsp_empty,
   input wire logic        rsp_pop,
   input wire logic [7:0]  rsp_read_data,
   input wire logic        rsp_read_valid,
   input wire logic        rsp_write_nack,
   input wire logic        rsp_flash_request,
   input wire logic [31:0] rsp_flash_address,
   input wire logic        rsp_start_application
);

   // reset leaves no result and holds off requests during the clearing pass
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> rsp_empty && req_full)
      else $error("result or request open right after reset");

   a_read_data_zero: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_read_valid |-> rsp_read_data == 8'd0)
      else $error("read data without read valid");

   a_flash_addr_zero: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_flash_request |-> rsp_flash_address == 32'd0)
      else $error("flash address without flash request");

   a_exclusive: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> !(rsp_read_valid && rsp_write_nack)
                     && !(rsp_flash_request && rsp_start_application))
      else $error("conflicting result flags");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_read_data)
                                 && $stable(rsp_flash_address))
      else $error("stalled result beat changed");

endmodule

bind i2c_register_map_bootloader_slave_core i2crm_checker u_i2crm_checker (.*);

`default_nettype wire
